### hw/rtl/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Widths, register indexes, reset values and policy codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

  localparam int CNT_W   = 16;
  localparam int DB_W    = 10;
  localparam int POL_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DISABLE_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_MAX_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_POLICY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED_AT_RESET    = 3'd5;

  localparam logic [DB_W-1:0]  DEBOUNCE_TICKS_RST     = 10'd100;
  localparam logic [CNT_W-1:0] LONG_ENABLE_TICKS_RST  = 16'd3000;
  localparam logic [CNT_W-1:0] LONG_DISABLE_TICKS_RST = 16'd5000;
  localparam logic [CNT_W-1:0] QUICK_MAX_TICKS_RST    = 16'd1000;

  localparam logic [POL_W-1:0] POLICY_TOGGLE         = 2'd0;
  localparam logic [POL_W-1:0] POLICY_NEVER_DISABLE  = 2'd1;
  localparam logic [POL_W-1:0] POLICY_REBOOT         = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/button_debounce_press_classifier_top.sv
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One raw button sample per transaction (one per millisecond tick), one result
// per transaction. For each sample, the state
// registers and the result register are updated at the edge where the sample
// is accepted, and the result is offered on the next cycle. A new sample can be
// taken every cycle as long as the result register is empty or being drained
// in the same cycle, so throughput is one sample per clock, set by the output
// register handshake. Configuration writes are taken every cycle (cfg_ready is
// always high); writing enabled_at_reset also loads the enabled level at once.
module button_debounce_press_classifier_top
  import bdpc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   pin_level,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  quick_press,
  output logic                  enabled_changed,
  output logic                  enabled_state,
  output logic                  reboot_request,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  logic [DB_W-1:0]  debounce_ticks;
  logic [CNT_W-1:0] long_enable_ticks;
  logic [CNT_W-1:0] long_disable_ticks;
  logic [CNT_W-1:0] quick_max_ticks;
  logic [POL_W-1:0] long_press_policy;

  logic             previous_sample, previous_sample_next;
  logic [DB_W-1:0]  debounce_count, debounce_count_next;
  logic             debounce_running, debounce_running_next;
  logic             stable_known, stable_known_next;
  logic             stable_level, stable_level_next;
  logic             press_seen, press_seen_next;
  logic [CNT_W-1:0] press_duration, press_duration_next;
  logic [CNT_W-1:0] long_count, long_count_next;
  logic             long_running, long_running_next;
  logic             enabled_level, enabled_level_next;

  logic             quick_next, changed_next, reboot_next;
  logic [CNT_W-1:0] long_load;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    previous_sample_next  = pin_level;
    debounce_count_next   = debounce_count;
    debounce_running_next = debounce_running;
    stable_known_next     = stable_known;
    stable_level_next     = stable_level;
    press_seen_next       = press_seen;
    press_duration_next   = press_duration;
    long_count_next       = long_count;
    long_running_next     = long_running;
    enabled_level_next    = enabled_level;
    quick_next            = 1'b0;
    changed_next          = 1'b0;
    reboot_next           = 1'b0;
    long_load             = '0;

    if (press_seen && press_duration != CNT_MAX) begin
      press_duration_next = press_duration + 1'b1;
    end

    if (long_running) begin
      if (long_count <= CNT_W'(1)) begin
        long_count_next   = '0;
        long_running_next = 1'b0;
        if (enabled_level && long_press_policy == POLICY_NEVER_DISABLE) begin
          // refuse to disable
        end else if (enabled_level && long_press_policy == POLICY_REBOOT) begin
          reboot_next = 1'b1;
        end else begin
          enabled_level_next = !enabled_level;
          changed_next       = 1'b1;
        end
      end else begin
        long_count_next = long_count - 1'b1;
      end
    end

    // load uses the enabled level after any long-press action this tick
    long_load = enabled_level_next ? long_disable_ticks : long_enable_ticks;
    if (long_load == '0) begin
      long_load = CNT_W'(1);
    end

    if (pin_level != previous_sample) begin
      debounce_count_next   = debounce_ticks;
      debounce_running_next = 1'b1;
    end else if (debounce_running) begin
      if (debounce_count <= DB_W'(1)) begin
        debounce_count_next   = '0;
        debounce_running_next = 1'b0;
        if (!stable_known || pin_level != stable_level) begin
          stable_known_next = 1'b1;
          stable_level_next = pin_level;
          if (pin_level) begin
            press_seen_next     = 1'b1;
            press_duration_next = '0;
            long_count_next     = long_load;
            long_running_next   = 1'b1;
          end else if (press_seen) begin
            long_running_next = 1'b0;
            long_count_next   = '0;
            quick_next        = (press_duration_next < quick_max_ticks);
          end
        end
      end else begin
        debounce_count_next = debounce_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_TICKS_RST;
      long_enable_ticks  <= LONG_ENABLE_TICKS_RST;
      long_disable_ticks <= LONG_DISABLE_TICKS_RST;
      quick_max_ticks    <= QUICK_MAX_TICKS_RST;
      long_press_policy  <= POLICY_TOGGLE;
      previous_sample    <= 1'b0;
      debounce_count     <= '0;
      debounce_running   <= 1'b0;
      stable_known       <= 1'b0;
      stable_level       <= 1'b0;
      press_seen         <= 1'b0;
      press_duration     <= '0;
      long_count         <= '0;
      long_running       <= 1'b0;
      enabled_level      <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (in_fire) begin
        previous_sample  <= previous_sample_next;
        debounce_count   <= debounce_count_next;
        debounce_running <= debounce_running_next;
        stable_known     <= stable_known_next;
        stable_level     <= stable_level_next;
        press_seen       <= press_seen_next;
        press_duration   <= press_duration_next;
        long_count       <= long_count_next;
        long_running     <= long_running_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // a restore write wins over the tick update
      if (cfg_valid && cfg_index == REG_ENABLED_AT_RESET) begin
        enabled_level <= cfg_data[0];
      end else if (in_fire) begin
        enabled_level <= enabled_level_next;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DEBOUNCE_TICKS:     debounce_ticks     <= cfg_data[DB_W-1:0];
          REG_LONG_ENABLE_TICKS:  long_enable_ticks  <= cfg_data[CNT_W-1:0];
          REG_LONG_DISABLE_TICKS: long_disable_ticks <= cfg_data[CNT_W-1:0];
          REG_QUICK_MAX_TICKS:    quick_max_ticks    <= cfg_data[CNT_W-1:0];
          REG_LONG_PRESS_POLICY:  long_press_policy  <= cfg_data[POL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      quick_press     <= quick_next;
      enabled_changed <= changed_next;
      enabled_state   <= enabled_level_next;
      reboot_request  <= reboot_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bdpc_checker.sv
// Port-level checks for the button debounce and press classifier.
// Uses only the handshake and result ports; bound to button_debounce_press_classifier_top.
`timescale 1ns / 1ps
`default_nettype none

module bdpc_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire quick_press,
  input wire enabled_changed,
  input wire enabled_state,
  input wire reboot_request
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quick_press)
      && $stable(enabled_changed) && $stable(enabled_state) && $stable(reboot_request))
    else $error("result changed while stalled");

  // an empty result register never blocks a sample
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a transaction always yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample produced no result");

  a_reboot_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && reboot_request |-> enabled_state && !enabled_changed)
    else $error("reboot request with toggle or while disabled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (.*);

`default_nettype wire
